// ===== rtl/core/mavt_pkg.sv =====
// ----------------------------------------------------------------------------
// mavt_pkg
// Shared widths, reset values, codes and types of the multiturn angle and
// velocity tracker.
// ----------------------------------------------------------------------------
package mavt_pkg;

    // field widths
    localparam int ANGLE_W    = 15;               // counts within one revolution
    localparam int CPR_LOG2   = ANGLE_W;          // 32768 counts per revolution
    localparam int STAMP_W    = 24;               // down-counting timer width
    localparam int TURN_W     = 32;
    localparam int POS_W      = 48;
    localparam int DELTA_W    = POS_W + 1;
    localparam int RATE_W     = 24;
    localparam int PROD_W     = DELTA_W + RATE_W;
    localparam int QUO_W      = 40;
    localparam int VEL_W      = QUO_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 40;               // raw_angle, timestamp, pad
    localparam int OUT_DATA_W = TURN_W + ANGLE_W + VEL_W;

    localparam int MUL_STEPS  = RATE_W;           // one multiplier bit per cycle
    localparam int DIV_STEPS  = QUO_W;            // one quotient bit per cycle

    // register reset values
    localparam logic [ANGLE_W-1:0] WRAP_THR_RST  = 15'd26214;
    localparam logic [RATE_W-1:0]  TICK_RATE_RST = 24'd9000000;
    localparam logic [STAMP_W-1:0] MAX_INT_RST   = 24'd4500000;
    localparam logic [STAMP_W-1:0] FALLBACK_RST  = 24'd9000;

    // turn count limits
    localparam logic [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};
    localparam logic [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};

    // velocity limits
    localparam logic [VEL_W-1:0] VEL_POS_SAT = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VEL_NEG_SAT = {1'b1, {(VEL_W-1){1'b0}}};

    // item modes
    localparam logic MODE_PRIME  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRAP_THR  = 2'd0,
        CFG_TICK_RATE = 2'd1,
        CFG_MAX_INT   = 2'd2,
        CFG_FALLBACK  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [ANGLE_W-1:0] wrap_thr;
        logic [RATE_W-1:0]  tick_rate;
        logic [STAMP_W-1:0] max_int;
        logic [STAMP_W-1:0] fallback;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

endpackage

// ===== rtl/core/mavt_track.sv =====
// ----------------------------------------------------------------------------
// mavt_track
// Angle unwrap, turn counting, elapsed tick selection and position delta.
// ----------------------------------------------------------------------------
module mavt_track (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_take,
    input  logic                                i_mode,
    input  logic [mavt_pkg::ANGLE_W-1:0]        i_raw,
    input  logic [mavt_pkg::STAMP_W-1:0]        i_stamp,
    input  mavt_pkg::t_cfg                      i_cfg,
    output logic [mavt_pkg::TURN_W-1:0]         o_turns,
    output logic [mavt_pkg::ANGLE_W-1:0]        o_angle,
    output logic signed [mavt_pkg::DELTA_W-1:0] o_delta,
    output logic [mavt_pkg::STAMP_W-1:0]        o_ticks,
    output logic                                o_go
);

    logic [mavt_pkg::ANGLE_W-1:0]        r_prev_raw;
    logic [mavt_pkg::TURN_W-1:0]         r_turns;
    logic [mavt_pkg::POS_W-1:0]          r_prev_pos;
    logic [mavt_pkg::STAMP_W-1:0]        r_prev_stamp;
    logic                                r_pend;
    logic                                r_go;
    logic signed [mavt_pkg::DELTA_W-1:0] r_delta;
    logic [mavt_pkg::STAMP_W-1:0]        r_ticks;

    logic signed [mavt_pkg::ANGLE_W:0]   w_diff;
    logic [mavt_pkg::ANGLE_W:0]          w_mag;
    logic                                w_jump;
    logic [mavt_pkg::TURN_W-1:0]         n_turns;
    logic [mavt_pkg::STAMP_W-1:0]        w_elapsed;
    logic [mavt_pkg::STAMP_W-1:0]        w_ticks;
    logic [mavt_pkg::POS_W-1:0]          w_pos;
    logic signed [mavt_pkg::DELTA_W-1:0] w_delta;

    always_comb begin
        w_diff = $signed({1'b0, i_raw}) - $signed({1'b0, r_prev_raw});
        w_mag  = w_diff[mavt_pkg::ANGLE_W] ? unsigned'(-w_diff) : unsigned'(w_diff);
        w_jump = w_mag > {1'b0, i_cfg.wrap_thr};

        // a forward jump is a backward wrap, and the other way round
        n_turns = r_turns;
        if (w_jump) begin
            if (!w_diff[mavt_pkg::ANGLE_W]) begin
                if (r_turns != mavt_pkg::TURN_MIN) n_turns = r_turns - 1'b1;
            end else begin
                if (r_turns != mavt_pkg::TURN_MAX) n_turns = r_turns + 1'b1;
            end
        end

        // timer counts down, so elapsed wraps modulo the timer range
        w_elapsed = r_prev_stamp - i_stamp;
        if (w_elapsed == '0 || w_elapsed > i_cfg.max_int) begin
            w_ticks = i_cfg.fallback;
        end else begin
            w_ticks = w_elapsed;
        end
        if (w_ticks == '0) w_ticks = {{(mavt_pkg::STAMP_W-1){1'b0}}, 1'b1};

        // position = turns * CPR + angle
        w_pos   = {r_turns[mavt_pkg::TURN_W-1], r_turns, r_prev_raw};
        w_delta = $signed({w_pos[mavt_pkg::POS_W-1], w_pos})
                - $signed({r_prev_pos[mavt_pkg::POS_W-1], r_prev_pos});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw   <= '0;
            r_turns      <= '0;
            r_prev_pos   <= '0;
            r_prev_stamp <= '0;
            r_pend       <= 1'b0;
            r_go         <= 1'b0;
        end else begin
            r_pend <= i_take && (i_mode == mavt_pkg::MODE_SAMPLE);
            r_go   <= r_pend;
            if (i_take) begin
                r_prev_raw <= i_raw;
                if (i_mode == mavt_pkg::MODE_SAMPLE) begin
                    r_turns      <= n_turns;
                    r_prev_stamp <= i_stamp;
                end else begin
                    r_turns      <= '0;
                    r_prev_stamp <= '0;
                end
            end
            if (r_pend) r_prev_pos <= w_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) r_ticks <= w_ticks;
        if (r_pend) r_delta <= w_delta;
    end

    assign o_turns = r_turns;
    assign o_angle = r_prev_raw;
    assign o_delta = r_delta;
    assign o_ticks = r_ticks;
    assign o_go    = r_go;

endmodule

// ===== rtl/core/mavt_mul.sv =====
// ----------------------------------------------------------------------------
// mavt_mul
// Serial shift-add multiplier: |delta| times tick rate, one rate bit a cycle.
// ----------------------------------------------------------------------------
module mavt_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [mavt_pkg::DELTA_W-1:0] i_delta,
    input  logic [mavt_pkg::RATE_W-1:0]         i_rate,
    output logic [mavt_pkg::PROD_W-1:0]         o_prod,
    output logic                                o_neg,
    output logic                                o_done
);

    localparam int CNT_W = $clog2(mavt_pkg::MUL_STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(mavt_pkg::MUL_STEPS - 1);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [mavt_pkg::DELTA_W-1:0] r_mcand;
    logic [mavt_pkg::PROD_W-1:0]  r_acc;
    logic                         r_neg;

    logic [mavt_pkg::DELTA_W-1:0] w_abs;
    logic [mavt_pkg::DELTA_W:0]   w_sum;

    always_comb begin
        w_abs = i_delta[mavt_pkg::DELTA_W-1] ? unsigned'(-i_delta) : unsigned'(i_delta);
        // upper part accumulates, multiplier bits shift out at the bottom
        w_sum = {1'b0, r_acc[mavt_pkg::PROD_W-1:mavt_pkg::RATE_W]}
              + (r_acc[0] ? {1'b0, r_mcand} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= w_abs;
            r_neg   <= i_delta[mavt_pkg::DELTA_W-1];
            r_acc   <= {{mavt_pkg::DELTA_W{1'b0}}, i_rate};
        end else if (r_busy) begin
            r_acc <= {w_sum, r_acc[mavt_pkg::RATE_W-1:1]};
        end
    end

    assign o_prod = r_acc;
    assign o_neg  = r_neg;
    assign o_done = r_done;

endmodule

// ===== rtl/core/mavt_div.sv =====
// ----------------------------------------------------------------------------
// mavt_div
// Serial restoring divider with overflow detect: product / ticks, one
// quotient bit a cycle.
// ----------------------------------------------------------------------------
module mavt_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mavt_pkg::PROD_W-1:0]  i_prod,
    input  logic [mavt_pkg::STAMP_W-1:0] i_div,
    output logic [mavt_pkg::QUO_W-1:0]   o_quo,
    output logic                         o_sat,
    output logic                         o_done
);

    localparam int HI_W  = mavt_pkg::PROD_W - mavt_pkg::QUO_W;
    localparam int REM_W = mavt_pkg::STAMP_W;
    localparam int CNT_W = $clog2(mavt_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(mavt_pkg::DIV_STEPS - 1);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [REM_W-1:0]           r_rem;
    logic [mavt_pkg::QUO_W-1:0] r_quo;
    logic                       r_sat;

    logic [HI_W-1:0]  w_hi;
    logic [REM_W:0]   w_shift;
    logic [REM_W+1:0] w_trial;
    logic             w_ge;

    always_comb begin
        w_hi    = i_prod[mavt_pkg::PROD_W-1:mavt_pkg::QUO_W];
        w_shift = {r_rem, r_quo[mavt_pkg::QUO_W-1]};
        w_trial = {1'b0, w_shift} - {2'b00, i_div};
        w_ge    = !w_trial[REM_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) r_busy <= 1'b0;
            end
        end
    end

    // quotient >= 2^40 exactly when the top bits already reach the divisor;
    // otherwise the top bits are the first partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat <= w_hi >= {{(HI_W-REM_W){1'b0}}, i_div};
            r_rem <= w_hi[REM_W-1:0];
            r_quo <= i_prod[mavt_pkg::QUO_W-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[REM_W-1:0] : w_shift[REM_W-1:0];
            r_quo <= {r_quo[mavt_pkg::QUO_W-2:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_sat  = r_sat;
    assign o_done = r_done;

endmodule

// ===== rtl/core/multiturn_angle_velocity_tracker_top.sv =====
// ----------------------------------------------------------------------------
// multiturn_angle_velocity_tracker_top
// Multiturn unwrap of a 15-bit sensor angle with velocity from timer ticks.
// ----------------------------------------------------------------------------
// A prime transaction (tuser 0) gives no result. A sample transaction (tuser 1)
// goes from acceptance to the output register in this order: the position delta
// is registered and the multiplier loaded, the serial multiplier runs (one
// tick-rate bit per cycle), the divider is loaded, the restoring divider runs
// (one quotient bit per cycle), and the signed velocity is handed to the output
// register. The input is ready again the cycle after the result is loaded, so
// a new sample is not accepted before the last one is through; the input stays
// busy once the velocity is ready only while the output register is not drained.
// Velocity is counts per second, truncated toward zero and saturated to
// 41 bits; turns saturate at the 32-bit limits. Configuration writes are taken
// every cycle and must only come while the block is idle.
module multiturn_angle_velocity_tracker_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mavt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mavt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mavt_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // raw_angle[14:0], timestamp[38:15], pad[39]
    input  logic                               s_axis_tuser,  // mode
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mavt_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // turns[31:0], angle[46:32], velocity[87:47]
);

    mavt_pkg::t_state r_state, n_state;
    mavt_pkg::t_cfg   r_cfg;

    logic w_take;
    logic w_mul_start;
    logic w_load;

    logic [mavt_pkg::TURN_W-1:0]         trk_turns;
    logic [mavt_pkg::ANGLE_W-1:0]        trk_angle;
    logic signed [mavt_pkg::DELTA_W-1:0] trk_delta;
    logic [mavt_pkg::STAMP_W-1:0]        trk_ticks;
    logic                                trk_go;

    logic [mavt_pkg::PROD_W-1:0] mul_prod;
    logic                        mul_neg;
    logic                        mul_done;

    logic [mavt_pkg::QUO_W-1:0] div_quo;
    logic                       div_sat;
    logic                       div_done;

    logic [mavt_pkg::VEL_W-1:0] w_vel;

    logic                         r_out_valid;
    logic [mavt_pkg::TURN_W-1:0]  r_out_turns;
    logic [mavt_pkg::ANGLE_W-1:0] r_out_angle;
    logic [mavt_pkg::VEL_W-1:0]   r_out_vel;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wrap_thr  <= mavt_pkg::WRAP_THR_RST;
            r_cfg.tick_rate <= mavt_pkg::TICK_RATE_RST;
            r_cfg.max_int   <= mavt_pkg::MAX_INT_RST;
            r_cfg.fallback  <= mavt_pkg::FALLBACK_RST;
        end else if (i_cfg_valid) begin
            unique case (mavt_pkg::t_cfg_idx'(i_cfg_index))
                mavt_pkg::CFG_WRAP_THR:  r_cfg.wrap_thr  <= i_cfg_data[mavt_pkg::ANGLE_W-1:0];
                mavt_pkg::CFG_TICK_RATE: r_cfg.tick_rate <= i_cfg_data[mavt_pkg::RATE_W-1:0];
                mavt_pkg::CFG_MAX_INT:   r_cfg.max_int   <= i_cfg_data[mavt_pkg::STAMP_W-1:0];
                mavt_pkg::CFG_FALLBACK:  r_cfg.fallback  <= i_cfg_data[mavt_pkg::STAMP_W-1:0];
                default: ;
            endcase
        end
    end

    mavt_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_mode  (s_axis_tuser),
        .i_raw   (s_axis_tdata[mavt_pkg::ANGLE_W-1:0]),
        .i_stamp (s_axis_tdata[mavt_pkg::ANGLE_W +: mavt_pkg::STAMP_W]),
        .i_cfg   (r_cfg),
        .o_turns (trk_turns),
        .o_angle (trk_angle),
        .o_delta (trk_delta),
        .o_ticks (trk_ticks),
        .o_go    (trk_go)
    );

    mavt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_delta (trk_delta),
        .i_rate  (r_cfg.tick_rate),
        .o_prod  (mul_prod),
        .o_neg   (mul_neg),
        .o_done  (mul_done)
    );

    mavt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_done),
        .i_prod  (mul_prod),
        .i_div   (trk_ticks),
        .o_quo   (div_quo),
        .o_sat   (div_sat),
        .o_done  (div_done)
    );

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mavt_pkg::S_IDLE: if (w_take && s_axis_tuser == mavt_pkg::MODE_SAMPLE)
                                  n_state = mavt_pkg::S_PREP;
            mavt_pkg::S_PREP: if (trk_go)   n_state = mavt_pkg::S_MUL;
            mavt_pkg::S_MUL:  if (mul_done) n_state = mavt_pkg::S_DIV;
            mavt_pkg::S_DIV:  if (div_done) n_state = mavt_pkg::S_EMIT;
            mavt_pkg::S_EMIT: if (!r_out_valid || m_axis_tready) n_state = mavt_pkg::S_IDLE;
            default:          n_state = mavt_pkg::S_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_mul_start   = 1'b0;
        w_load        = 1'b0;
        unique case (r_state)
            mavt_pkg::S_IDLE: s_axis_tready = 1'b1;
            mavt_pkg::S_PREP: w_mul_start   = trk_go;
            mavt_pkg::S_EMIT: w_load        = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    assign w_take = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mavt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sign and clamp the magnitude quotient
    always_comb begin
        if (div_sat) begin
            w_vel = mul_neg ? mavt_pkg::VEL_NEG_SAT : mavt_pkg::VEL_POS_SAT;
        end else if (mul_neg) begin
            w_vel = -{1'b0, div_quo};
        end else begin
            w_vel = {1'b0, div_quo};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_turns <= trk_turns;
            r_out_angle <= trk_angle;
            r_out_vel   <= w_vel;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_vel, r_out_angle, r_out_turns};

endmodule

// ===== sim/tb_multiturn_angle_velocity_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiturn_angle_velocity_tracker_top
// Self-checking bench for the multiturn tracker. A scoreboard tracks turns,
// position and timer state on every accepted sensor item, predicts turns,
// angle and velocity, and checks each result in order. A short directed part
// covers wrap, interval fallback and velocity saturation. It is followed by
// random motion tracks under several register settings, with bursty input
// and a stalling result side.
// ----------------------------------------------------------------------------
module tb_multiturn_angle_velocity_tracker_top;
    import mavt_pkg::*;

    localparam int          QUIET_LIMIT   = 20000;  // cycles with no transaction
    localparam int          SETTLE_CYCLES = 80;     // sample latency plus margin
    localparam int          HOLD_AFTER    = 400;    // inputs taken before the long stall
    localparam int          HOLD_CYCLES   = 3000;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [127:0] VEL_SPAN     = 128'd1 << QUO_W;

    // same bit order as m_axis_tdata: turns lowest
    typedef struct packed {
        logic [VEL_W-1:0]   velocity;
        logic [ANGLE_W-1:0] angle;
        logic [TURN_W-1:0]  turns;
    } motion_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_style_t;

    class motion_scoreboard;
        t_cfg                     regs;
        logic [ANGLE_W-1:0]       last_raw;
        logic signed [TURN_W-1:0] turns;
        longint                   last_pos;
        logic [STAMP_W-1:0]       last_stamp;
        motion_t                  motion_due[$];
        int unsigned              errors;

        function new();
            regs = '{wrap_thr: WRAP_THR_RST, tick_rate: TICK_RATE_RST,
                     max_int: MAX_INT_RST, fallback: FALLBACK_RST};
            last_raw   = '0;
            turns      = '0;
            last_pos   = 0;
            last_stamp = '0;
            errors     = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_WRAP_THR:  regs.wrap_thr  = value[ANGLE_W-1:0];
                CFG_TICK_RATE: regs.tick_rate = value[RATE_W-1:0];
                CFG_MAX_INT:   regs.max_int   = value[STAMP_W-1:0];
                CFG_FALLBACK:  regs.fallback  = value[STAMP_W-1:0];
                default: ;
            endcase
        endfunction

        function void log_sensor_item(logic mode, logic [ANGLE_W-1:0] raw,
                                      logic [STAMP_W-1:0] stamp);
            int                 jump;
            logic [STAMP_W-1:0] elapsed;
            logic [STAMP_W-1:0] ticks;
            longint             pos;
            longint             delta;
            logic [127:0]       quo;
            motion_t            m;
            if (mode == MODE_PRIME) begin
                // position history survives a prime, the timer reference does not
                last_raw   = raw;
                turns      = '0;
                last_stamp = '0;
                return;
            end
            jump = int'(raw) - int'(last_raw);
            if ((jump < 0 ? -jump : jump) > int'(regs.wrap_thr)) begin
                if (jump > 0) begin
                    if (turns != TURN_MIN) turns = turns - 1;
                end else if (turns != TURN_MAX) begin
                    turns = turns + 1;
                end
            end
            last_raw = raw;

            elapsed = last_stamp - stamp;  // down-counter, wraps mod 2^24
            ticks = (elapsed == '0 || elapsed > regs.max_int) ? regs.fallback : elapsed;
            if (ticks == '0) ticks = 24'd1;

            pos   = longint'(turns) * (longint'(1) << CPR_LOG2) + longint'(raw);
            delta = pos - last_pos;
            quo   = (128'(delta < 0 ? -delta : delta) * 128'(regs.tick_rate)) / 128'(ticks);
            if (quo > VEL_SPAN) quo = VEL_SPAN;
            if (delta < 0)
                m.velocity = -quo[VEL_W-1:0];
            else
                m.velocity = (quo >= VEL_SPAN) ? VEL_POS_SAT : quo[VEL_W-1:0];
            m.turns = turns;
            m.angle = raw;

            last_pos   = pos;
            last_stamp = stamp;
            motion_due.push_back(m);
        endfunction

        function void check_motion(logic [OUT_DATA_W-1:0] bus);
            motion_t got;
            motion_t want;
            got = bus;
            if (motion_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: turns %0d angle %0d velocity %0d",
                             $signed(got.turns), got.angle, $signed(got.velocity));
                return;
            end
            want = motion_due.pop_front();
            if (got.turns !== want.turns || got.angle !== want.angle
                    || got.velocity !== want.velocity) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result mismatch: turns %0d/%0d angle %0d/%0d velocity %0d/%0d (exp/act)",
                             $signed(want.turns), $signed(got.turns), want.angle, got.angle,
                             $signed(want.velocity), $signed(got.velocity));
            end
        endfunction

        function int unsigned pending();
            return motion_due.size();
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_WRAP_THR;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // raw_angle, timestamp, pad
    logic                  s_axis_tuser  = MODE_PRIME;  // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;  // turns, angle, velocity

    motion_scoreboard book;
    int unsigned      items_taken = 0;
    int unsigned      burst_left  = 0;
    bit               gaps_on     = 1'b1;
    rx_style_t        rx_style    = RX_OPEN;
    int unsigned      rx_left     = 0;
    int unsigned      rx_hold     = 0;
    bit               rx_held     = 1'b0;

    multiturn_angle_velocity_tracker_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // transaction monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                book.set_reg(t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) begin
                book.log_sensor_item(s_axis_tuser, s_axis_tdata[ANGLE_W-1:0],
                                     s_axis_tdata[ANGLE_W +: STAMP_W]);
                items_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
                book.check_motion(m_axis_tdata);
        end
    end

    // result side: randomly chosen stall styles, each held for a random stretch, one long hold
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (!rx_held && items_taken >= HOLD_AFTER) begin
            rx_held = 1'b1;
            rx_hold = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_style = rx_style_t'($urandom_range(0, 3));
                rx_left  = $urandom_range(16, 400);
            end
            rx_left--;
            case (rx_style)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
                default:   m_axis_tready <= (rx_left[2:0] != 3'd0);
            endcase
        end
    end

    // watchdog
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready)
                    || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic offer_item(input logic mode, input logic [ANGLE_W-1:0] raw,
                              input logic [STAMP_W-1:0] stamp);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, stamp, raw};
        do @(posedge i_clk); while (!s_axis_tready);
        if (gaps_on && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 90)) @(posedge i_clk);
            burst_left = $urandom_range(0, 24);
        end else if (burst_left != 0) begin
            burst_left--;
        end
    endtask

    // wait for the block to go idle before touching registers
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (book.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] thr,
                                 input logic [CFG_DATA_W-1:0] rate,
                                 input logic [CFG_DATA_W-1:0] max_ticks,
                                 input logic [CFG_DATA_W-1:0] fallback);
        t_cfg_idx              order[4];
        logic [CFG_DATA_W-1:0] vals[4];
        order = '{CFG_WRAP_THR, CFG_TICK_RATE, CFG_MAX_INT, CFG_FALLBACK};
        vals  = '{thr, rate, max_ticks, fallback};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= order[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // motion tracks: usually a prime, then a run at a steady step with the odd jump
    task automatic run_tracks(input int unsigned n_items);
        logic [ANGLE_W-1:0] angle;
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] dt;
        int                 step;
        int unsigned        sent;
        sent  = 0;
        angle = $urandom;
        stamp = $urandom;
        while (sent < n_items) begin
            if ($urandom_range(0, 3) != 0) begin
                angle = $urandom;
                offer_item(MODE_PRIME, angle, $urandom);
                stamp = '0;
                sent++;
            end
            step = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 16000) : $urandom_range(0, 300);
            if ($urandom_range(0, 1) != 0) step = -step;
            repeat ($urandom_range(4, 60)) begin
                if ($urandom_range(0, 15) == 0)
                    angle = $urandom;
                else
                    angle = angle + step[ANGLE_W-1:0];
                case ($urandom_range(0, 9))
                    0:       dt = '0;
                    1:       dt = $urandom;
                    2:       dt = 24'd1;
                    default: dt = $urandom_range(1, 20000);
                endcase
                stamp = stamp - dt;
                offer_item(MODE_SAMPLE, angle, stamp);
                sent++;
            end
        end
    endtask

    initial begin
        int unsigned        climb[6];
        int unsigned        slide[5];
        logic [STAMP_W-1:0] t;
        book       = new();
        burst_left = $urandom_range(0, 24);
        climb = '{0, 16000, 32000, 15000, 31000, 14000};
        slide = '{17000, 1000, 17500, 2000, 18500};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero and long intervals, wrap both ways, threshold edge
        offer_item(MODE_SAMPLE, 15'd0, 24'd0);
        offer_item(MODE_SAMPLE, 15'h7FFF, 24'hFFFFFF);
        offer_item(MODE_SAMPLE, 15'd0, 24'hFFFFFE);
        offer_item(MODE_SAMPLE, 15'd26214, 24'h7FFFFE);
        offer_item(MODE_SAMPLE, 15'd0, 24'h7FFFFE - 24'd4500000);
        offer_item(MODE_SAMPLE, 15'd26215, 24'h7FFFFE - 24'd4500001);
        offer_item(MODE_PRIME, 15'h5555, 24'hAAAAAA);
        offer_item(MODE_SAMPLE, 15'h2AAA, 24'h555555);

        // one tick per sample at full rate: build turns, prime, saturate both ways
        settle();
        load_settings(24'd16383, 24'hFFFFFF, 24'hFFFFFF, 24'd0);
        t = 24'h555555;
        foreach (climb[k]) begin
            t = t - 24'd1;
            offer_item(MODE_SAMPLE, climb[k][ANGLE_W-1:0], t);
        end
        offer_item(MODE_PRIME, 15'd0, 24'h123456);
        t = 24'hFFFFFF;
        offer_item(MODE_SAMPLE, 15'd0, t);
        offer_item(MODE_SAMPLE, 15'd0, t);  // zero interval, zero fallback
        foreach (slide[k]) begin
            t = t - 24'd1;
            offer_item(MODE_SAMPLE, slide[k][ANGLE_W-1:0], t);
        end
        offer_item(MODE_PRIME, 15'd0, 24'h0);
        offer_item(MODE_SAMPLE, 15'd0, 24'hFFFFFF);

        settle();
        load_settings(24'd0, 24'd1, 24'd0, 24'd1);
        run_tracks(250);

        settle();
        load_settings(24'd32767, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        run_tracks(250);

        settle();
        gaps_on = 1'b0;
        load_settings(24'd12000, 24'd0, 24'd5000, 24'd0);
        run_tracks(150);

        for (int p = 0; p < 5; p++) begin
            settle();
            gaps_on = ($urandom_range(0, 2) != 0);
            load_settings($urandom_range(0, 32767), $urandom_range(0, 24'hFFFFFF),
                          ($urandom_range(0, 1) != 0) ? $urandom_range(0, 30000) : $urandom,
                          $urandom_range(0, 30000));
            run_tracks(250);
        end

        settle();
        if (book.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mavt_pkg.sv
rtl/core/mavt_track.sv
rtl/core/mavt_mul.sv
rtl/core/mavt_div.sv
rtl/core/multiturn_angle_velocity_tracker_top.sv
sim/tb_multiturn_angle_velocity_tracker_top.sv
